/* sv/positional_sequential_list_defines.svh */
// assertion macros for the positional sequential list
`ifndef POSITIONAL_SEQUENTIAL_LIST_DEFINES_SVH
`define POSITIONAL_SEQUENTIAL_LIST_DEFINES_SVH

`ifndef SYNTHESIS
`define PSL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psl check failed");
`define PSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psl check failed");
`else
`define PSL_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PSL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* sv/psl_pkg.sv */
// shared types and codes for the positional sequential list
`default_nettype none

package psl_pkg;

  localparam int ACTION_W = 3;
  localparam int POS_W    = 6;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_INS_AT    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REM_FRONT = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REM_BACK  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_REM_AT    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic ins;
    logic rem;
  } psl_cmd_t;

endpackage

`default_nettype wire

/* sv/psl_cell.sv */
// one storage cell of the list chain
`default_nettype none

module psl_cell
  import psl_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int IW         = 5,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire psl_cmd_t              cmd,
  input  wire logic [IW-1:0]         at,
  input  wire logic [DATA_WIDTH-1:0] data_in,
  input  wire logic [DATA_WIDTH-1:0] left,
  input  wire logic [DATA_WIDTH-1:0] right,
  output logic      [DATA_WIDTH-1:0] value,
  output logic      [DATA_WIDTH-1:0] tap
);

  localparam logic [IW-1:0] IDX = IW'(INDEX);

  always_ff @(posedge clk) begin
    if (cmd.ins && at == IDX) begin
      value <= data_in;
    end else if (cmd.ins && at < IDX) begin
      value <= left;
    end else if (cmd.rem && at <= IDX) begin
      value <= right;
    end
  end

  assign tap = (at == IDX) ? value : '0;

endmodule

`default_nettype wire

/* sv/psl_ctrl.sv */
// count, operation decode and result register of the list
`default_nettype none

`include "positional_sequential_list_defines.svh"

module psl_ctrl
  import psl_pkg::*;
#(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [ACTION_W-1:0]   action,
  input  wire logic [POS_W-1:0]      position,
  input  wire logic [DATA_WIDTH-1:0] tap_word,
  output psl_cmd_t                   cmd,
  output logic      [IW-1:0]         at,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [STATUS_W-1:0]   out_status,
  output logic      [WORD_W-1:0]     out_removed,
  output logic      [COUNT_W-1:0]    out_count
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int MAXW = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [CMPW-1:0]     cnt_w;
  logic [CMPW-1:0]     pos_w;
  logic [CMPW-1:0]     at_w;
  logic [STATUS_W-1:0] status;
  logic [MAXW-1:0]     removed_w;
  logic                fire;
  logic                is_ins;
  logic                is_rem;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign cnt_w    = CMPW'(count);
  assign pos_w    = CMPW'(position);
  assign is_ins   = action == ACT_INS_FRONT || action == ACT_INS_BACK ||
                    action == ACT_INS_AT;
  assign is_rem   = action == ACT_REM_FRONT || action == ACT_REM_BACK ||
                    action == ACT_REM_AT;

  always_comb begin
    status     = ST_OK;
    at_w       = '0;
    cmd        = '0;
    count_next = count;
    case (action)
      ACT_INS_FRONT: at_w = '0;
      ACT_INS_BACK:  at_w = cnt_w;
      ACT_INS_AT:    at_w = pos_w;
      ACT_REM_FRONT: at_w = '0;
      ACT_REM_BACK:  at_w = cnt_w - CMPW'(1);
      ACT_REM_AT:    at_w = pos_w;
      default:       at_w = '0;
    endcase
    if (is_ins) begin
      if (count == CW'(DEPTH)) begin
        status = ST_FULL;
      end else if (at_w > cnt_w) begin
        status = ST_RANGE;
      end else begin
        cmd.ins    = fire;
        count_next = count + CW'(1);
      end
    end else if (is_rem) begin
      if (count == '0) begin
        status = ST_EMPTY;
      end else if (at_w >= cnt_w) begin
        status = ST_RANGE;
      end else begin
        cmd.rem    = fire;
        count_next = count - CW'(1);
      end
    end
    at = at_w[IW-1:0];
  end

  assign removed_w = (is_rem && status == ST_OK) ? MAXW'(tap_word) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        count <= count_next;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status  <= status;
      out_removed <= removed_w[WORD_W-1:0];
      out_count   <= COUNT_W'(CMPW'(count_next));
    end
  end

  `PSL_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `PSL_ASSERT_IMPLY(a_removed_zero, clk, rst, out_valid && out_status != ST_OK,
                    out_removed == '0)
  `PSL_ASSERT_NEXT(a_ins_count, clk, rst, cmd.ins,
                   count == $past(count) + CW'(1))
  `PSL_ASSERT_NEXT(a_rem_count, clk, rst, cmd.rem,
                   count == $past(count) - CW'(1))

endmodule

`default_nettype wire

/* sv/positional_sequential_list.sv */
// positional sequential list: chain of storage cells with insert and remove
//
// input items on s_*: action, position and a data word; each item asks for an
// insert at the front, back or a position, or a removal from the front, back
// or a position. every item gives exactly one result item on m_*: a status
// (ok, full, empty, bad position), the removed word (zero unless a removal
// succeeded) and the count held afterwards.
// entries live in a row of DEPTH cells; an insert shifts every cell at and
// above the slot up by one and a removal shifts the cells above it down, all
// cells moving in the same clock.
// the result is registered and shows in the cycle after acceptance.
// throughput: one item per cycle while m_tready stays high.
// when the receiver stalls, the result is held and s_tready drops until it
// is taken; no item is lost.
// reset empties the list at once (count to zero); cell contents are not
// cleared and are only read below the count.
`default_nettype none

module positional_sequential_list
  import psl_pkg::*;
#(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // action[2:0], position[8:3], entry_data[40:9], zero [47:41]
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // status[1:0], removed_data[33:2], count_after[39:34]
  output logic      [OUT_TDATA_W-1:0] m_tdata
);

  localparam int IW   = $clog2(DEPTH);
  localparam int MAXW = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;

  logic [ACTION_W-1:0]   action;
  logic [POS_W-1:0]      position;
  logic [WORD_W-1:0]     entry_data;
  logic [MAXW-1:0]       data_w;
  logic [DATA_WIDTH-1:0] data_in;
  psl_cmd_t              cmd;
  logic [IW-1:0]         at;
  logic [DATA_WIDTH-1:0] value [DEPTH];
  logic [DATA_WIDTH-1:0] tap [DEPTH];
  logic [DATA_WIDTH-1:0] tap_word;
  logic [STATUS_W-1:0]   status;
  logic [WORD_W-1:0]     removed_data;
  logic [COUNT_W-1:0]    count_after;

  assign action     = s_tdata[2:0];
  assign position   = s_tdata[8:3];
  assign entry_data = s_tdata[40:9];
  assign data_w     = MAXW'(entry_data);
  assign data_in    = data_w[DATA_WIDTH-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = value[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = value[i];
    end else begin : g_inner
      assign right = value[i+1];
    end
    psl_cell #(
      .INDEX      (i),
      .IW         (IW),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .at      (at),
      .data_in (data_in),
      .left    (left),
      .right   (right),
      .value   (value[i]),
      .tap     (tap[i])
    );
  end

  always_comb begin
    tap_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_word = tap_word | tap[i];
    end
  end

  psl_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IW         (IW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .action      (action),
    .position    (position),
    .tap_word    (tap_word),
    .cmd         (cmd),
    .at          (at),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (status),
    .out_removed (removed_data),
    .out_count   (count_after)
  );

  assign m_tdata = {count_after, removed_data, status};

endmodule

`default_nettype wire

/* bench/list_op_checker.sv */
// checker for the positional sequential list: predicts each result and compares it
`timescale 1ns / 100ps

module list_op_checker
  import psl_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  // action[2:0], position[8:3], entry_data[40:9], zero [47:41]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // status[1:0], removed_data[33:2], count_after[39:34]
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     fail_count,
  output int                     outstanding,
  output int                     list_fill,
  output int                     results_seen
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   removed;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  logic [WORD_W-1:0] cells [DEPTH];
  int                held;
  int                errors;
  int                seen;
  list_result_t      results_due [$];

  initial begin
    held = 0;
    errors = 0;
    seen = 0;
    fail_count = 0;
    outstanding = 0;
    list_fill = 0;
    results_seen = 0;
  end

  task automatic apply_list_op(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                               input logic [WORD_W-1:0] word, output list_result_t res);
    int slot;
    res = '0;
    res.status = ST_OK;
    case (act)
      ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
        slot = (act == ACT_INS_FRONT) ? 0 : (act == ACT_INS_BACK) ? held : int'(pos);
        if (held >= DEPTH) begin
          res.status = ST_FULL;
        end else if (slot > held) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = held; i > slot; i--) cells[i] = cells[i-1];
          cells[slot] = word;
          held++;
        end
      end
      ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_AT: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          slot = (act == ACT_REM_FRONT) ? 0 : (act == ACT_REM_BACK) ? held - 1 : int'(pos);
          if (slot >= held) begin
            res.status = ST_RANGE;
          end else begin
            res.removed = cells[slot];
            for (int i = slot; i + 1 < held; i++) cells[i] = cells[i+1];
            held--;
          end
        end
      end
      default: ;
    endcase
    res.count = held[COUNT_W-1:0];
  endtask

  always @(posedge clk) begin : watch
    list_result_t got;
    list_result_t want;
    list_result_t fresh;
    if (rst) begin
      results_due.delete();
      held = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen++;
        got.status  = m_tdata[STATUS_W-1:0];
        got.removed = m_tdata[STATUS_W +: WORD_W];
        got.count   = m_tdata[STATUS_W+WORD_W +: COUNT_W];
        if (results_due.size() == 0) begin
          $display("%0t: unexpected item: status %0d removed %h count %0d", $time,
                   got.status, got.removed, got.count);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.removed !== want.removed) begin
            $display("%0t: removed_data expected %h got %h", $time, want.removed, got.removed);
            errors++;
          end
          if (got.count !== want.count) begin
            $display("%0t: count_after expected %0d got %0d", $time, want.count, got.count);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        apply_list_op(s_tdata[ACTION_W-1:0], s_tdata[ACTION_W +: POS_W],
                      s_tdata[ACTION_W+POS_W +: WORD_W], fresh);
        results_due.push_back(fresh);
      end
    end
    fail_count   <= errors;
    outstanding  <= results_due.size();
    list_fill    <= held;
    results_seen <= seen;
  end

endmodule

/* bench/tb_top.sv */
// testbench top for the positional sequential list: stimulus, handshake timing and verdict
`timescale 1ns / 100ps

module tb_top
  import psl_pkg::*;
();

  localparam int CLK_PERIOD   = 8;
  localparam int LIST_DEPTH   = 32;
  localparam int RANDOM_ITEMS = 1100;
  localparam int LONG_HOLD    = 150;

  // action codes the block ignores
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef enum {FILL, DRAIN, WANDER} trend_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int fail_count;
  int outstanding;
  int list_fill;
  int results_seen;
  bit burst_mode = 1'b0;
  bit long_hold_done = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  positional_sequential_list #(.DEPTH(LIST_DEPTH), .DATA_WIDTH(WORD_W)) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  list_op_checker #(.DEPTH(LIST_DEPTH)) op_check (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .fail_count(fail_count),
    .outstanding(outstanding),
    .list_fill(list_fill),
    .results_seen(results_seen)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_op(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                         input logic [WORD_W-1:0] word);
    logic [IN_TDATA_W-1:0] packed_item;
    int gap;
    packed_item = '0;
    packed_item[ACTION_W-1:0] = act;
    packed_item[ACTION_W +: POS_W] = pos;
    packed_item[ACTION_W+POS_W +: WORD_W] = word;
    s_tdata <= packed_item;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // sender stops until every result is back
  task automatic drain_wait();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  initial begin : receiver
    int hold;
    do @(negedge clk); while (rst);
    forever begin
      if (!long_hold_done && results_seen >= 400) begin
        m_tready <= 1'b0;
        hold = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        hold = pick_gap() + 1;
      end else begin
        m_tready <= 1'b1;
        hold = $urandom_range(1, 24);
      end
      repeat (hold) @(negedge clk);
    end
  end

  initial begin : sender
    trend_t                trend;
    int                    edge_hits;
    int                    wander_left;
    int                    ins_pct;
    logic [ACTION_W-1:0]   act;
    logic [POS_W-1:0]      pos;
    logic [WORD_W-1:0]     word;
    trend = FILL;
    edge_hits = 0;
    wander_left = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty list, ignored codes, bad positions, front and back, append at count
    push_op(ACT_REM_FRONT, 0, 32'h0);
    push_op(ACT_REM_BACK, 0, 32'h0);
    push_op(ACT_REM_AT, 0, 32'h0);
    push_op(ACT_SPARE_LO, 32, 32'hFFFF_FFFF);
    push_op(ACT_SPARE_HI, 0, 32'h0);
    push_op(ACT_INS_AT, 1, 32'h1111_1111);
    push_op(ACT_INS_AT, 0, 32'h0000_0000);
    push_op(ACT_INS_BACK, 0, 32'hFFFF_FFFF);
    push_op(ACT_INS_FRONT, 0, 32'h5A5A_5A5A);
    push_op(ACT_INS_AT, 3, 32'h8000_0001);
    push_op(ACT_INS_AT, 5, 32'hDEAD_BEEF);
    push_op(ACT_INS_AT, 32, 32'hDEAD_BEEF);
    push_op(ACT_INS_AT, 2, 32'h1234_5678);
    push_op(ACT_REM_AT, 5, 32'h0);
    push_op(ACT_REM_AT, 32, 32'h0);
    push_op(ACT_REM_AT, 2, 32'h0);
    push_op(ACT_REM_AT, 0, 32'h0);
    push_op(ACT_REM_BACK, 0, 32'h0);
    push_op(ACT_REM_FRONT, 0, 32'h0);
    push_op(ACT_REM_FRONT, 0, 32'h0);
    push_op(ACT_REM_BACK, 0, 32'h0);
    drain_wait();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 128 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      case (trend)
        FILL: begin
          ins_pct = 85;
          if (list_fill == LIST_DEPTH) edge_hits++;
          if (edge_hits > 3) begin
            trend = DRAIN;
            edge_hits = 0;
          end
        end
        DRAIN: begin
          ins_pct = 15;
          if (list_fill == 0) edge_hits++;
          if (edge_hits > 3) begin
            trend = WANDER;
            edge_hits = 0;
            wander_left = $urandom_range(20, 80);
            if ($urandom_range(0, 1) == 0) drain_wait();
          end
        end
        default: begin
          ins_pct = 50;
          wander_left--;
          if (wander_left <= 0) trend = FILL;
        end
      endcase

      if ($urandom_range(0, 49) == 0) begin
        act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
      end else if ($urandom_range(0, 99) < ins_pct) begin
        case ($urandom_range(0, 2))
          0:       act = ACT_INS_FRONT;
          1:       act = ACT_INS_BACK;
          default: act = ACT_INS_AT;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       act = ACT_REM_FRONT;
          1:       act = ACT_REM_BACK;
          default: act = ACT_REM_AT;
        endcase
      end

      if ($urandom_range(0, 3) == 0) pos = POS_W'($urandom_range(0, LIST_DEPTH));
      else if (act == ACT_INS_AT) pos = POS_W'($urandom_range(0, list_fill));
      else pos = (list_fill > 0) ? POS_W'($urandom_range(0, list_fill - 1)) : '0;

      case ($urandom_range(0, 9))
        0:       word = '0;
        1:       word = '1;
        default: word = $urandom;
      endcase

      push_op(act, pos, word);
    end

    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4ms;
    $display("Verification failed");
    $finish;
  end

endmodule
